@@ hdl/hcsm_pkg.sv @@
// shared types, constants and the commutation table for the hall commutation core
`default_nettype none
package hcsm_pkg;

    localparam int TIME_W     = 63;
    localparam int SPEED_W    = 32;
    localparam int PPR_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 40;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [PPR_W-1:0]   PPR_RESET = 8'd15;
    localparam logic [SPEED_W-1:0] NUM_RESET = 32'd60000000;

    localparam logic [CFG_IDX_W-1:0] REG_PPR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM = 1'b1;

    localparam logic [1:0] DRV_OFF = 2'd0;
    localparam logic [1:0] DRV_LOW = 2'd1;
    localparam logic [1:0] DRV_PWM = 2'd2;

    typedef struct packed {
        logic [1:0] g;
        logic [1:0] b;
        logic [1:0] y;
    } t_drive;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_needed;
        logic out_free;
    } t_dp_status;

    // hall code is y | b<<1 | g<<2
    function automatic t_drive drive_lookup(input logic [2:0] code);
        t_drive d;
        d = '{g: DRV_OFF, b: DRV_OFF, y: DRV_OFF};
        case (code)
            3'd1:    d = '{g: DRV_LOW, b: DRV_OFF, y: DRV_PWM};
            3'd2:    d = '{g: DRV_OFF, b: DRV_PWM, y: DRV_LOW};
            3'd3:    d = '{g: DRV_LOW, b: DRV_PWM, y: DRV_OFF};
            3'd4:    d = '{g: DRV_PWM, b: DRV_LOW, y: DRV_OFF};
            3'd5:    d = '{g: DRV_OFF, b: DRV_LOW, y: DRV_PWM};
            3'd6:    d = '{g: DRV_PWM, b: DRV_OFF, y: DRV_LOW};
            default: d = '{g: DRV_OFF, b: DRV_OFF, y: DRV_OFF};
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

@@ hdl/hcsm_ctrl.sv @@
// sequencing state machine for the hall commutation core
`default_nettype none
module hcsm_ctrl
    import hcsm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_RESULT
    } t_state;

    t_state               r_state;
    logic [DIV_CNT_W-1:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_step  <= '0;
                    r_state <= i_status.div_needed ? S_DIV : S_RESULT;
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == DIV_CNT_W'(DIV_STEPS - 1)) r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (i_status.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_in_ready      = (r_state == S_IDLE);
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.eval      = (r_state == S_EVAL);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.out_load  = (r_state == S_RESULT) && i_status.out_free;
    end

endmodule
`default_nettype wire

@@ hdl/hcsm_dp.sv @@
// datapath: speed accumulation, bit-serial divider and output register
`default_nettype none
module hcsm_dp
    import hcsm_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire  [2:0]             i_hall_code,
    input  wire                    i_capture,
    input  wire  [SPEED_W-1:0]     i_time_lo,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_status             o_status,
    input  wire                    i_out_ready,
    output logic                   o_out_valid,
    output logic [OUT_DATA_W-1:0]  o_out_data
);

    logic [PPR_W-1:0]   r_ppr;
    logic [SPEED_W-1:0] r_num;
    logic [2:0]         r_code;
    logic               r_cap;
    logic [SPEED_W-1:0] r_time;
    logic [SPEED_W-1:0] r_rise;
    logic [SPEED_W-1:0] r_sum;
    logic [PPR_W-1:0]   r_count;
    logic [SPEED_W-1:0] r_div;
    logic [SPEED_W-1:0] r_rem;
    logic [SPEED_W-1:0] r_quo;
    logic               r_rep_valid;
    logic               r_rep_dz;
    logic               r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [SPEED_W-1:0] w_high;
    logic [SPEED_W-1:0] w_sum_new;
    logic [PPR_W:0]     w_next;
    logic               w_report;
    logic               w_zero;
    logic [SPEED_W:0]   w_trial;
    logic [SPEED_W:0]   w_diff;
    logic               w_ge;
    t_drive             w_drive;

    // high time wraps mod 2^32, so only the low timestamp bits matter
    assign w_high    = r_time - r_rise;
    assign w_sum_new = r_sum + w_high;
    assign w_next    = {1'b0, r_count} + 1'b1;
    assign w_report  = r_cap && !r_code[0] && (w_next >= {1'b0, r_ppr});
    assign w_zero    = (w_sum_new == '0);

    assign w_trial = {r_rem, r_quo[SPEED_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = !w_diff[SPEED_W];

    assign w_drive = drive_lookup(r_code);

    assign o_status.div_needed = w_report && !w_zero;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr <= PPR_RESET;
            r_num <= NUM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PPR: r_ppr <= i_cfg_data[PPR_W-1:0];
                REG_NUM: r_num <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // speed state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise  <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.eval && r_cap) begin
            if (r_code[0]) begin
                r_rise <= r_time;
            end else if (w_report) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= w_sum_new;
                r_count <= w_next[PPR_W-1:0];
            end
        end
    end

    // word capture, report flags and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_code <= i_hall_code;
            r_cap  <= i_capture;
            r_time <= i_time_lo;
        end
        if (i_cmd.eval) begin
            r_rep_valid <= w_report && !w_zero;
            r_rep_dz    <= w_report && w_zero;
            r_div       <= w_sum_new;
            r_rem       <= '0;
            r_quo       <= r_num;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[SPEED_W-1:0] : w_trial[SPEED_W-1:0];
            r_quo <= {r_quo[SPEED_W-2:0], w_ge};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {r_rep_dz,
                           r_rep_valid ? r_quo : {SPEED_W{1'b0}},
                           r_rep_valid,
                           w_drive.g, w_drive.b, w_drive.y};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

@@ hdl/hall_commutation_with_speed_measure_core.sv @@
// top level of the six-step hall commutation core with speed measurement
// sequence: an accepted word is captured, then evaluated; if a speed report with a
// nonzero sum is due, 32 divider steps run; the result loads once the output is free
// throughput: a new word is accepted only after the last result has loaded, so a due
// report holds the input through the 32-step bit-serial divider
// reset: synchronous active low; clears the period count, period sum, rise time,
// the output valid and loads 15 periods per report and a numerator of 60000000
`default_nettype none
module hall_commutation_with_speed_measure_core
    import hcsm_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // hall_y[0], hall_b[1], hall_g[2], time_us[65:3], zero fill[71:66]
    input  wire  [IN_DATA_W-1:0]   i_s_axis_tdata,
    // y_capture_fired[0]
    input  wire  [IN_USER_W-1:0]   i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    // phase_y_drive[1:0], phase_b_drive[3:2], phase_g_drive[5:4], speed_valid[6],
    // speed_rpm[38:7], speed_div_zero[39]
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    hcsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    hcsm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_hall_code (i_s_axis_tdata[2:0]),
        .i_capture   (i_s_axis_tuser[0]),
        .i_time_lo   (i_s_axis_tdata[3 +: SPEED_W]),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

    // a result never carries both a speed and a zero-sum error
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[6] && o_m_axis_tdata[39]))
        else $error("speed_valid and speed_div_zero both set");

    // rpm reads zero whenever no speed is reported
    a_rpm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[6]) |-> (o_m_axis_tdata[38:7] == '0))
        else $error("speed_rpm nonzero without speed_valid");

    // one word at a time: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while a word is in flight");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for the hall commutation core with speed measurement
`timescale 1ns / 1ps
module tb_top;
    import hcsm_pkg::*;

    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_PRINTED     = 100;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    // forward six-step hall order, code y | b<<1 | g<<2, position 0 in the low bits
    localparam logic [17:0] HALL_ORDER = {3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};

    typedef struct {
        logic              y;
        logic              b;
        logic              g;
        logic              cap;
        logic [TIME_W-1:0] t;
    } hall_event_t;

    typedef struct {
        logic [1:0]         phase_y;
        logic [1:0]         phase_b;
        logic [1:0]         phase_g;
        logic               speed_valid;
        logic [SPEED_W-1:0] speed_rpm;
        logic               div_zero;
    } drive_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_PPR;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  snk_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // predictor state and its copy of the registers
    logic [PPR_W-1:0]   model_ppr;
    logic [SPEED_W-1:0] model_num;
    logic [PPR_W-1:0]   model_count;
    logic [SPEED_W-1:0] model_sum;
    logic [TIME_W-1:0]  model_rise;

    drive_result_t pending_drive_results[$];
    int            mismatches = 0;
    int            results_seen = 0;

    // motor used to build well-formed hall sequences
    logic [TIME_W-1:0] motor_us = '0;
    int                motor_pos = 0;
    logic              motor_y = 1'b1;

    logic src_gaps_on = 1'b1;
    logic snk_gaps_on = 1'b1;
    logic hold_req = 1'b0;

    wire in_word  = s_tvalid & s_tready;
    wire out_word = m_tvalid & snk_ready;

    hall_commutation_with_speed_measure_core DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (snk_ready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic drive_result_t predict_commutation(input hall_event_t ev);
        drive_result_t     r;
        logic [TIME_W-1:0] high_full;
        logic [8:0]        next_count;
        r.speed_valid = 1'b0;
        r.speed_rpm   = '0;
        r.div_zero    = 1'b0;
        case ({ev.g, ev.b, ev.y})
            3'd1:    {r.phase_y, r.phase_b, r.phase_g} = {DRV_PWM, DRV_OFF, DRV_LOW};
            3'd2:    {r.phase_y, r.phase_b, r.phase_g} = {DRV_LOW, DRV_PWM, DRV_OFF};
            3'd3:    {r.phase_y, r.phase_b, r.phase_g} = {DRV_OFF, DRV_PWM, DRV_LOW};
            3'd4:    {r.phase_y, r.phase_b, r.phase_g} = {DRV_OFF, DRV_LOW, DRV_PWM};
            3'd5:    {r.phase_y, r.phase_b, r.phase_g} = {DRV_PWM, DRV_LOW, DRV_OFF};
            3'd6:    {r.phase_y, r.phase_b, r.phase_g} = {DRV_LOW, DRV_OFF, DRV_PWM};
            default: {r.phase_y, r.phase_b, r.phase_g} = {DRV_OFF, DRV_OFF, DRV_OFF};
        endcase
        if (ev.cap) begin
            if (ev.y) begin
                model_rise = ev.t;
            end else begin
                // high time only matters mod 2^32
                high_full  = ev.t - model_rise;
                model_sum  = model_sum + high_full[31:0];
                next_count = {1'b0, model_count} + 9'd1;
                if (next_count >= {1'b0, model_ppr}) begin
                    if (model_sum == '0) begin
                        r.div_zero = 1'b1;
                    end else begin
                        r.speed_valid = 1'b1;
                        r.speed_rpm   = model_num / model_sum;
                    end
                    model_count = '0;
                    model_sum   = '0;
                end else begin
                    model_count = next_count[PPR_W-1:0];
                end
            end
        end
        return r;
    endfunction

    function automatic logic [TIME_W-1:0] random_delta();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 90) return TIME_W'($urandom_range(1, 2000));
        if (r < 97) return TIME_W'($urandom_range(2000, 200000));
        return TIME_W'($urandom);
    endfunction

    function automatic hall_event_t next_motor_step();
        hall_event_t ev;
        logic [2:0]  code;
        // mostly forward rotation, sometimes a step back
        motor_pos = ($urandom_range(9) == 0) ? (motor_pos + 5) % 6 : (motor_pos + 1) % 6;
        code      = HALL_ORDER[motor_pos*3 +: 3];
        motor_us  = motor_us + random_delta();
        ev.y      = code[0];
        ev.b      = code[1];
        ev.g      = code[2];
        ev.cap    = (code[0] != motor_y);
        ev.t      = motor_us;
        motor_y   = code[0];
        return ev;
    endfunction

    // y toggles on every event, for long period counts
    function automatic hall_event_t next_y_toggle();
        hall_event_t ev;
        motor_y  = ~motor_y;
        motor_us = motor_us + random_delta();
        ev.y     = motor_y;
        ev.b     = 1'($urandom_range(1));
        ev.g     = 1'($urandom_range(1));
        ev.cap   = ($urandom_range(9) != 0);
        ev.t     = motor_us;
        return ev;
    endfunction

    function automatic hall_event_t random_noise_event();
        hall_event_t ev;
        logic [63:0] r64;
        r64    = {$urandom, $urandom};
        ev.y   = 1'($urandom_range(1));
        ev.b   = 1'($urandom_range(1));
        ev.g   = 1'($urandom_range(1));
        ev.cap = 1'($urandom_range(1));
        ev.t   = r64[TIME_W-1:0];
        return ev;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < MAX_PRINTED)
            $display("mismatch: %s on result %0d, got %0h expected %0h",
                     what, results_seen, got, want);
        mismatches++;
    endtask

    task automatic send_event(input hall_event_t ev);
        if (src_gaps_on && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, ev.t, ev.g, ev.b, ev.y};
        s_tuser  <= ev.cap;
        do @(posedge clk); while (!s_tready);
        pending_drive_results.push_back(predict_commutation(ev));
    endtask

    task automatic send_levels(input logic y, input logic b, input logic g,
                               input logic cap, input logic [TIME_W-1:0] t);
        hall_event_t ev;
        ev = '{y: y, b: b, g: g, cap: cap, t: t};
        send_event(ev);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_PPR) model_ppr = val[PPR_W-1:0];
        else model_num = val;
    endtask

    task automatic wait_idle(input int extra);
        s_tvalid <= 1'b0;
        while (pending_drive_results.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic run_random(input int count, input int clean_pct, input bit y_only);
        hall_event_t ev;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < clean_pct)
                ev = y_only ? next_y_toggle() : next_motor_step();
            else
                ev = random_noise_event();
            send_event(ev);
        end
    endtask

    // all eight hall codes under reset settings, no captures
    task automatic test_drive_table();
        for (int code = 0; code < 8; code++)
            send_levels(code[0], code[1], code[2], 1'b0, code[0] ? TIME_MAX : '0);
        wait_idle(8);
    endtask

    task automatic test_speed_edges();
        write_reg(REG_PPR, 32'd1);
        write_reg(REG_NUM, 32'hFFFF_FFFF);
        // zero high time gives the divide-by-zero flag
        send_levels(1'b1, 1'b0, 1'b1, 1'b1, '0);
        send_levels(1'b0, 1'b1, 1'b1, 1'b1, '0);
        // one microsecond, largest rpm
        send_levels(1'b1, 1'b0, 1'b0, 1'b1, TIME_W'(100));
        send_levels(1'b0, 1'b1, 1'b0, 1'b1, TIME_W'(101));
        // fall earlier than the stored rise
        send_levels(1'b0, 1'b1, 1'b1, 1'b1, TIME_W'(50));
        // timestamp wraps between rise and fall
        send_levels(1'b1, 1'b0, 1'b1, 1'b1, TIME_MAX);
        send_levels(1'b0, 1'b0, 1'b1, 1'b1, TIME_W'(5));
        wait_idle(8);
    endtask

    task automatic test_zero_numerator();
        write_reg(REG_NUM, 32'd0);
        send_levels(1'b1, 1'b1, 1'b0, 1'b1, TIME_W'(1000));
        send_levels(1'b0, 1'b1, 1'b0, 1'b1, TIME_W'(1700));
        wait_idle(8);
    endtask

    task automatic test_ppr_lowered();
        write_reg(REG_PPR, 32'd3);
        write_reg(REG_NUM, NUM_RESET);
        send_levels(1'b1, 1'b0, 1'b1, 1'b1, TIME_W'(2000));
        send_levels(1'b0, 1'b1, 1'b0, 1'b1, TIME_W'(2500));
        send_levels(1'b1, 1'b0, 1'b1, 1'b1, TIME_W'(3000));
        send_levels(1'b0, 1'b1, 1'b0, 1'b1, TIME_W'(3400));
        wait_idle(8);
        // count already at two, so the next period reports
        write_reg(REG_PPR, 32'd1);
        send_levels(1'b1, 1'b0, 1'b1, 1'b1, TIME_W'(4000));
        send_levels(1'b0, 1'b1, 1'b0, 1'b1, TIME_W'(4300));
        wait_idle(8);
    endtask

    task automatic test_ppr_zero();
        write_reg(REG_PPR, 32'd0);
        send_levels(1'b1, 1'b0, 1'b0, 1'b1, TIME_W'(5000));
        send_levels(1'b0, 1'b1, 1'b1, 1'b1, TIME_W'(5900));
        wait_idle(8);
    endtask

    task automatic test_motor_backpressure();
        logic [63:0] r64;
        r64      = {$urandom, $urandom};
        motor_us = r64[TIME_W-1:0];
        write_reg(REG_PPR, {24'b0, PPR_RESET});
        write_reg(REG_NUM, NUM_RESET);
        hold_req = 1'b1;
        run_random(400, 85, 1'b0);
        wait_idle(8);
    endtask

    task automatic test_long_count();
        write_reg(REG_PPR, 32'd255);
        write_reg(REG_NUM, 32'hFFFF_FFFF);
        src_gaps_on = 1'b0;
        snk_gaps_on = 1'b0;
        run_random(560, 95, 1'b1);
        wait_idle(8);
        src_gaps_on = 1'b1;
        snk_gaps_on = 1'b1;
    endtask

    task automatic test_every_period();
        write_reg(REG_PPR, 32'd1);
        write_reg(REG_NUM, $urandom);
        run_random(250, 70, 1'b0);
        wait_idle(8);
    endtask

    task automatic test_random_config();
        write_reg(REG_PPR, CFG_DATA_W'($urandom_range(2, 20)));
        write_reg(REG_NUM, $urandom);
        run_random(315, 85, 1'b0);
        wait_idle(40);
    endtask

    initial begin : main
        model_ppr   = PPR_RESET;
        model_num   = NUM_RESET;
        model_count = '0;
        model_sum   = '0;
        model_rise  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_drive_table();
        test_speed_edges();
        test_zero_numerator();
        test_ppr_lowered();
        test_ppr_zero();
        test_motor_backpressure();
        test_long_count();
        test_every_period();
        test_random_config();
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // result side ready, with random stalls and one long hold-off on request
    initial begin : sink
        forever begin
            @(posedge clk);
            if (hold_req) begin
                snk_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (snk_gaps_on && $urandom_range(99) < 13) begin
                snk_ready <= 1'b0;
            end else begin
                snk_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : result_check
        drive_result_t         want;
        logic [OUT_DATA_W-1:0] word;
        if (rst_n && out_word) begin
            word = m_tdata;
            if (pending_drive_results.size() == 0) begin
                flag_mismatch("word with nothing expected", word[31:0], '0);
            end else begin
                want = pending_drive_results.pop_front();
                if (word[1:0] !== want.phase_y)
                    flag_mismatch("phase_y_drive", word[1:0], want.phase_y);
                if (word[3:2] !== want.phase_b)
                    flag_mismatch("phase_b_drive", word[3:2], want.phase_b);
                if (word[5:4] !== want.phase_g)
                    flag_mismatch("phase_g_drive", word[5:4], want.phase_g);
                if (word[6] !== want.speed_valid)
                    flag_mismatch("speed_valid", word[6], want.speed_valid);
                if (word[38:7] !== want.speed_rpm)
                    flag_mismatch("speed_rpm", word[38:7], want.speed_rpm);
                if (word[39] !== want.div_zero)
                    flag_mismatch("speed_div_zero", word[39], want.div_zero);
            end
            results_seen++;
        end
    end

    // ends the run when no word moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || in_word || out_word) quiet = 0;
            else quiet++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
